### design/argb_pixel_blend_top_defines.svh
// ----------------------------------------------------------------------------
// argb_pixel_blend_top_defines
// Assertion macros for the ARGB pixel blend block.
// ----------------------------------------------------------------------------
`ifndef ARGB_PIXEL_BLEND_TOP_DEFINES_SVH
`define ARGB_PIXEL_BLEND_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define ABPB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ABPB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ABPB_ASSERT(lbl, prop, msg)

`define ABPB_ASSERT_RST(lbl, prop, msg)

`endif

`endif

### design/abpb_pkg.sv
// ----------------------------------------------------------------------------
// abpb_pkg
// Shared types, constants and helpers of the ARGB pixel blend block.
// ----------------------------------------------------------------------------
package abpb_pkg;

   localparam int CHAN_COUNT = 3;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 32;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int ALPHA_LSB  = CHAN_COUNT * CHAN_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_COPY,
      MODE_KEY,
      MODE_ADD,
      MODE_INTERP
   } blend_mode_type;

   typedef enum logic {
      CSR_IDX_BLEND_MODE,
      CSR_IDX_NONE
   } csr_index_type;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PROD_W-1:0] prod_type;

   // products and difference signs after the multiply stage
   typedef struct packed {
      logic [PIXEL_W-1:0]              src;
      logic [PIXEL_W-1:0]              dst;
      prod_type [CHAN_COUNT-1:0]       prod;
      logic [CHAN_COUNT-1:0]           ge;
   } prod_stage_type;

   // scaled channel terms after the divide stage
   typedef struct packed {
      logic [PIXEL_W-1:0]              src;
      logic [PIXEL_W-1:0]              dst;
      chan_type [CHAN_COUNT-1:0]       quot;
      logic [CHAN_COUNT-1:0]           ge;
   } div_stage_type;

   // floor(x / 255) for x up to 255 * 255
   function automatic chan_type div255(input prod_type x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

### design/argb_pixel_blend_top.sv
// ----------------------------------------------------------------------------
// argb_pixel_blend_top
// Blends a source ARGB pixel into a destination pixel under a selectable
// mode: copy, alpha key, saturating additive or alpha interpolate.
//
// Usage:
//   request channel: req_source_pixel and req_dest_pixel with req_valid;
//   a request is taken on an edge where req_valid is high and req_stall low.
//   result channel: rsp_blended_pixel with rsp_valid, held while rsp_stall.
//   config: APB port, blend_mode at byte address 0, pready always high;
//   change the mode only while no request is in flight.
//   path: a request passes the multiply, divide by 255, mix and output
//   register stages before rsp_valid rises.
//   throughput: one request per cycle while the result is not stalled;
//   every stage holds one request and a full pipeline still advances in
//   any cycle the result is taken.
//   stall: a stalled result holds the output register; stages behind it
//   keep filling, and req_stall rises once the pipeline is full.
//   reset: synchronous; empties the pipeline and sets copy mode.
// ----------------------------------------------------------------------------
`include "argb_pixel_blend_top_defines.svh"

module argb_pixel_blend_top import abpb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_W-1:0]    req_source_pixel,
   input  logic [PIXEL_W-1:0]    req_dest_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIXEL_W-1:0]    rsp_blended_pixel,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   blend_mode_type mode;
   logic           prod_valid;
   logic           prod_stall;
   prod_stage_type prod_data;
   logic           div_valid;
   logic           div_stall;
   div_stage_type  div_data;
   logic           mode_wr;
   logic [1:0]     rd_mode;
   logic [1:0]     wr_data;

   assign mode_wr = csr_psel && csr_penable && csr_pwrite && !csr_paddr[CSR_ADDR_W-1];
   assign rd_mode = csr_prdata[1:0];
   assign wr_data = csr_pwdata[1:0];

   abpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   abpb_prod_stage u_prod (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_src    (req_source_pixel),
      .in_dst    (req_dest_pixel),
      .out_valid (prod_valid),
      .out_stall (prod_stall),
      .out_data  (prod_data)
   );

   abpb_div_stage u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_stall  (prod_stall),
      .in_data   (prod_data),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_data  (div_data)
   );

   abpb_mix_stage u_mix (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode),
      .in_valid  (div_valid),
      .in_stall  (div_stall),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_pixel (rsp_blended_pixel)
   );

   `ABPB_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")

   `ABPB_ASSERT(a_empty_no_stall, !rsp_valid |-> !req_stall, "request stalled with empty output")

   `ABPB_ASSERT(a_mode_readback, mode_wr |=> rd_mode == $past(wr_data), "mode readback mismatch")

endmodule

### design/abpb_csr.sv
// ----------------------------------------------------------------------------
// abpb_csr
// APB register file holding the blend mode.
// ----------------------------------------------------------------------------
module abpb_csr import abpb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output blend_mode_type        mode
);

   blend_mode_type mode_ff;
   blend_mode_type mode_in;
   csr_index_type  index;
   logic           wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      if (wr_en && index == CSR_IDX_BLEND_MODE) begin
         mode_in = blend_mode_type'(csr_pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COPY;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      unique case (index)
         CSR_IDX_BLEND_MODE: csr_prdata = {{(CSR_DATA_W - 2){1'b0}}, mode_ff};
         CSR_IDX_NONE:       csr_prdata = '0;
      endcase
   end

   assign mode = mode_ff;

endmodule

### design/abpb_prod_stage.sv
// ----------------------------------------------------------------------------
// abpb_prod_stage
// First stage: per-channel operand select and 8x8 multiply by source alpha.
// ----------------------------------------------------------------------------
module abpb_prod_stage import abpb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  blend_mode_type      mode,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [PIXEL_W-1:0]  in_src,
   input  logic [PIXEL_W-1:0]  in_dst,
   output logic                out_valid,
   input  logic                out_stall,
   output prod_stage_type      out_data
);

   logic           valid_ff;
   logic           valid_in;
   prod_stage_type data_ff;
   prod_stage_type data_in;
   logic           load;
   chan_type       alpha;

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;
   assign valid_in = load ? in_valid : valid_ff;
   assign alpha    = in_src[PIXEL_W-1:ALPHA_LSB];

   always_comb begin
      chan_type s;
      chan_type d;
      chan_type opnd;
      data_in.src = in_src;
      data_in.dst = in_dst;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         s = in_src[i*CHAN_W +: CHAN_W];
         d = in_dst[i*CHAN_W +: CHAN_W];
         data_in.ge[i] = (s >= d);
         if (mode == MODE_ADD) begin
            opnd = s;
         end else if (s >= d) begin
            opnd = s - d;
         end else begin
            opnd = d - s;
         end
         data_in.prod[i] = {{CHAN_W{1'b0}}, opnd} * {{CHAN_W{1'b0}}, alpha};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### design/abpb_div_stage.sv
// ----------------------------------------------------------------------------
// abpb_div_stage
// Second stage: divides each channel product by 255 with a reciprocal form.
// ----------------------------------------------------------------------------
module abpb_div_stage import abpb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  prod_stage_type in_data,
   output logic           out_valid,
   input  logic           out_stall,
   output div_stage_type  out_data
);

   logic          valid_ff;
   logic          valid_in;
   div_stage_type data_ff;
   div_stage_type data_in;
   logic          load;

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;
   assign valid_in = load ? in_valid : valid_ff;

   always_comb begin
      data_in.src = in_data.src;
      data_in.dst = in_data.dst;
      data_in.ge  = in_data.ge;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         data_in.quot[i] = div255(in_data.prod[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### design/abpb_mix_stage.sv
// ----------------------------------------------------------------------------
// abpb_mix_stage
// Third stage: channel add or interpolate, saturation, mode select and
// output register.
// ----------------------------------------------------------------------------
module abpb_mix_stage import abpb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  blend_mode_type      mode,
   input  logic                in_valid,
   output logic                in_stall,
   input  div_stage_type       in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [PIXEL_W-1:0]  out_pixel
);

   logic               valid_ff;
   logic               valid_in;
   logic [PIXEL_W-1:0] pixel_ff;
   logic [PIXEL_W-1:0] pixel_in;
   logic               load;
   chan_type           alpha;
   logic [PIXEL_W-1:0] add_px;
   logic [PIXEL_W-1:0] mix_px;

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;
   assign valid_in = load ? in_valid : valid_ff;
   assign alpha    = in_data.src[PIXEL_W-1:ALPHA_LSB];

   always_comb begin
      chan_type        d;
      chan_type        q;
      logic [CHAN_W:0] sum;
      add_px = in_data.dst;
      mix_px = in_data.dst;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         d   = in_data.dst[i*CHAN_W +: CHAN_W];
         q   = in_data.quot[i];
         sum = {1'b0, d} + {1'b0, q};
         add_px[i*CHAN_W +: CHAN_W] = sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
         mix_px[i*CHAN_W +: CHAN_W] = in_data.ge[i] ? d + q : d - q;
      end
   end

   always_comb begin
      unique case (mode)
         MODE_COPY: pixel_in = in_data.src;
         MODE_KEY:  pixel_in = (alpha != '0) ? in_data.src : in_data.dst;
         MODE_ADD:  pixel_in = add_px;
         MODE_INTERP: begin
            if (alpha == {CHAN_W{1'b1}}) begin
               pixel_in = in_data.src;
            end else if (alpha == '0) begin
               pixel_in = in_data.dst;
            end else begin
               pixel_in = mix_px;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

### verif/argb_pixel_blend_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_pixel_blend_top_test
// Self-checking bench for the ARGB pixel blend block. It programs every blend
// mode over the APB port, sends directed and random pixel pairs with random
// request gaps and result stalls, predicts each blended pixel in a small
// scoreboard and compares the results in order.
// ----------------------------------------------------------------------------
module argb_pixel_blend_top_test import abpb_pkg::*; ();

   localparam int          LATENCY      = 3;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          RANDOM_COUNT = 1950;
   localparam int unsigned CHAN_MAX     = 255;

   class blended_pixel_tracker;
      blend_mode_type     mode;
      logic [PIXEL_W-1:0] expected_pixels[$];
      int                 mismatches;

      function new();
         mode       = MODE_COPY;
         mismatches = 0;
      endfunction

      function void apply_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr[CSR_ADDR_W-1:2] == CSR_IDX_BLEND_MODE) begin
            mode = blend_mode_type'(data[1:0]);
         end
      endfunction

      function logic [PIXEL_W-1:0] blend_pixel(logic [PIXEL_W-1:0] s, logic [PIXEL_W-1:0] d);
         int unsigned        a;
         int unsigned        sc;
         int unsigned        dc;
         int unsigned        v;
         logic [PIXEL_W-1:0] r;
         a = 32'(s[ALPHA_LSB +: CHAN_W]);
         r = d;
         case (mode)
            MODE_COPY: begin
               r = s;
            end
            MODE_KEY: begin
               r = (a != 0) ? s : d;
            end
            MODE_ADD: begin
               for (int i = 0; i < CHAN_COUNT; i++) begin
                  sc = 32'(s[i*CHAN_W +: CHAN_W]);
                  dc = 32'(d[i*CHAN_W +: CHAN_W]);
                  v  = dc + (sc * a) / CHAN_MAX;
                  r[i*CHAN_W +: CHAN_W] = CHAN_W'((v > CHAN_MAX) ? CHAN_MAX : v);
               end
            end
            default: begin
               if (a == CHAN_MAX) begin
                  r = s;
               end else if (a != 0) begin
                  for (int i = 0; i < CHAN_COUNT; i++) begin
                     sc = 32'(s[i*CHAN_W +: CHAN_W]);
                     dc = 32'(d[i*CHAN_W +: CHAN_W]);
                     if (sc >= dc) v = dc + ((sc - dc) * a) / CHAN_MAX;
                     else v = dc - ((dc - sc) * a) / CHAN_MAX;
                     r[i*CHAN_W +: CHAN_W] = CHAN_W'(v);
                  end
               end
            end
         endcase
         return r;
      endfunction

      function void note_request(logic [PIXEL_W-1:0] s, logic [PIXEL_W-1:0] d);
         expected_pixels.push_back(blend_pixel(s, d));
      endfunction

      function void check_pixel(logic [PIXEL_W-1:0] actual);
         logic [PIXEL_W-1:0] want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", actual);
         end else begin
            want = expected_pixels.pop_front();
            if (actual !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("blended_pixel mismatch: expected %h actual %h", want, actual);
               end
            end
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_source_pixel;
   logic [PIXEL_W-1:0]    req_dest_pixel;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIXEL_W-1:0]    rsp_blended_pixel;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   blended_pixel_tracker tracker = new();
   int                   idle_cycles = 0;
   int                   req_quiet   = 0;
   int                   rsp_quiet   = 0;
   int                   req_total   = 0;

   argb_pixel_blend_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_source_pixel  (req_source_pixel),
      .req_dest_pixel    (req_dest_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_pixel (rsp_blended_pixel),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length per request or result, with runs of back-to-back traffic
   function automatic int draw_idle(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   task automatic wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      repeat (LATENCY + 1) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.apply_csr(addr, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic send_request(input logic [PIXEL_W-1:0] s, input logic [PIXEL_W-1:0] d);
      int gap;
      gap = draw_idle(req_quiet);
      // hold off now and then until the pipeline has emptied
      if (req_total % 97 == 50) begin
         @(negedge clock);
         req_valid = 1'b0;
         wait_drained();
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_source_pixel = s;
      req_dest_pixel   = d;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.note_request(s, d);
      req_total++;
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random(input int count);
      logic [PIXEL_W-1:0] s;
      logic [PIXEL_W-1:0] d;
      for (int i = 0; i < count; i++) begin
         s = $urandom;
         d = $urandom;
         case ($urandom_range(0, 6))
            0: s[ALPHA_LSB +: CHAN_W] = 8'h00;
            1: s[ALPHA_LSB +: CHAN_W] = 8'hff;
            2: s[ALPHA_LSB +: CHAN_W] = CHAN_W'($urandom_range(1, 2));
            3: d[ALPHA_LSB-1:0] = s[ALPHA_LSB-1:0];
            4: d[ALPHA_LSB-1:0] = {ALPHA_LSB{1'b1}};
            default: ;
         endcase
         send_request(s, d);
      end
      end_requests();
   endtask

   // result stall
   initial begin
      int k;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         k = draw_idle(rsp_quiet);
         repeat (k) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_pixel(rsp_blended_pixel);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [PIXEL_W-1:0] dir_src[6];
      logic [PIXEL_W-1:0] dir_dst[6];
      int                 sent;
      int                 n;
      logic [CSR_DATA_W-1:0] word;

      dir_src = '{32'h0000_0000, 32'hffff_ffff, 32'hff12_3456,
                  32'h00ff_80ff, 32'h80ff_0040, 32'h01ff_ffff};
      dir_dst = '{32'h0000_0000, 32'hffff_ffff, 32'h00fe_dcba,
                  32'hffff_ffff, 32'h4000_ff40, 32'hfe00_0000};

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_source_pixel = '0;
      req_dest_pixel   = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed pairs under every mode, upper data bits set on the last one
      for (int m = 0; m < 4; m++) begin
         word = (m == MODE_INTERP) ? 32'hffff_fffc | MODE_INTERP : m;
         write_csr({CSR_IDX_BLEND_MODE, 2'b00}, word);
         if (m == MODE_KEY) write_csr({CSR_IDX_NONE, 2'b00}, 32'hffff_ffff);
         for (int i = 0; i < 6; i++) send_request(dir_src[i], dir_dst[i]);
         end_requests();
      end

      sent = 0;
      while (sent < RANDOM_COUNT) begin
         n    = $urandom_range(60, 240);
         if (n > RANDOM_COUNT - sent) n = RANDOM_COUNT - sent;
         word = $urandom;
         if ($urandom_range(0, 7) == 0) write_csr({CSR_IDX_NONE, 2'b00}, $urandom);
         write_csr({CSR_IDX_BLEND_MODE, 2'b00}, word);
         send_random(n);
         sent += n;
      end

      wait_drained();
      repeat (LATENCY + 5) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
